>>> src/teu_pkg.sv
// Shared constants, types and elaboration helpers of the target existence update pipeline.
package teu_pkg;

  // Number formats
  localparam int PF   = 16;            // probability fraction bits
  localparam int PW   = PF + 1;        // probability width, 1.0 = 2^PF
  localparam int LF   = 24;            // log2 / exp2 fraction bits
  localparam int DW   = 48;            // density width
  localparam int TW   = 32;            // time width, signed Q16.16
  localparam int NW   = 2 * PF + DW + 2; // posterior numerator / denominator width
  localparam int IN_W = 184;           // input tdata width
  localparam int OUT_W = 40;           // output tdata width
  localparam int CFG_IW = 3;           // config index width

  localparam logic [PW-1:0] ONE = {1'b1, {PF{1'b0}}};

  // Config register indexes
  localparam logic [CFG_IW-1:0] CFG_PERSIST  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_STAY     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_RECOVERY = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_GATE     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_VMODE    = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_UPDATE   = 3'd5;

  // Power lane outcome codes
  localparam logic [1:0] PW_NORM = 2'd0;
  localparam logic [1:0] PW_ONE  = 2'd1;
  localparam logic [1:0] PW_ZERO = 2'd2;

  // Divider outcome codes
  localparam logic [1:0] DV_RUN = 2'd0;
  localparam logic [1:0] DV_ONE = 2'd1;
  localparam logic [1:0] DV_FB  = 2'd2;

  // Pipeline stage map
  localparam int ST_IN   = 0;
  localparam int ST_XMUL = ST_IN + LF + 1;
  localparam int ST_EXP0 = ST_XMUL + 1;
  localparam int ST_POW  = ST_EXP0 + LF;
  localparam int ST_PRED = ST_POW + 1;
  localparam int ST_P1   = ST_PRED + 1;
  localparam int ST_P2   = ST_P1 + 1;
  localparam int ST_P3   = ST_P2 + 1;
  localparam int ST_P4   = ST_P3 + 1;
  localparam int ST_SEL  = ST_P4 + 1;
  localparam int ST_INIT = ST_SEL + 1;
  localparam int ST_DIV0 = ST_INIT + 1;
  localparam int NST     = ST_DIV0 + PF;

  // One power lane: log2 state, then exp2 state
  typedef struct packed {
    logic [1:0]    code;
    logic [4:0]    k;
    logic [30:0]   m;
    logic [LF-1:0] f;
    logic [4:0]    ip;
    logic [LF-1:0] y;
    logic [32:0]   e;
    logic [PW-1:0] pw;
  } lane_t;

  // One fraction divider
  typedef struct packed {
    logic [NW-1:0] num;
    logic [NW-1:0] den;
    logic [PF-1:0] q;
    logic [PW-1:0] fb;
    logic [1:0]    code;
  } div_t;

  // Full item state carried down the pipeline
  typedef struct packed {
    logic          kind;
    logic [PW-1:0] r;
    logic [PW-1:0] v;
    logic [PW-1:0] rr;
    logic [PW-1:0] vr;
    logic [30:0]   t;
    logic [PW-1:0] pd;
    logic [PW-1:0] x;
    logic [DW-1:0] g;
    logic [DW-1:0] lc;
    lane_t         le;
    lane_t         ll;
    logic [PW-1:0] vrem;
    logic [PF-1:0] vq;
    logic          vone;
    logic [PW-1:0] rp;
    logic [PW-1:0] vp;
    logic [PW-1:0] a;
    logic [32:0]   rvp;
    logic [32:0]   vx;
    logic [32:0]   rx;
    logic [PW-1:0] omr;
    logic [PW-1:0] omx;
    logic [32:0]   apd;
    logic [32:0]   dv;
    logic [32:0]   numv;
    logic [32:0]   numi;
    logic [32:0]   deni;
    logic [48:0]   denr;
    logic [40:0]   lclo;
    logic [40:0]   lchi;
    logic [56:0]   glo;
    logic [56:0]   ghi;
    logic [49:0]   numr;
    logic [80:0]   hnum;
    logic [64:0]   lct;
    div_t          de;
    div_t          dvv;
  } item_t;

  // Floor square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = n;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Factor 2^(-2^-idx) in Q0.32, from repeated square roots
  function automatic logic [31:0] exp_coef(input int idx);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 1; j < idx; j++) begin
      c = isqrt64({c[31:0], 32'b0});
    end
    return c[31:0];
  endfunction

endpackage

>>> src/target_existence_update.sv
// Throughput: one beat per cycle while the output is not stalled; 74 pipeline stages
// plus the output register, set by the 24-step log2 and exp2 lanes and the 16-step
// posterior dividers.
// A stall at the output freezes every stage at once; nothing is dropped or repeated.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the config
// registers with their defaults.
module target_existence_update (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // existence_prior, visibility_prior, elapsed_time, detect_prob,
  // likelihood_density, clutter_density (from bit 0 up), zero fill
  input  logic [teu_pkg::IN_W-1:0]        in_tdata,
  // kind
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // existence_post, visibility_post (from bit 0 up), zero fill
  output logic [teu_pkg::OUT_W-1:0]       out_tdata,
  input  logic                            cfg_we,
  input  logic [teu_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [teu_pkg::PW-1:0]          cfg_wdata
);

  localparam int PW  = teu_pkg::PW;
  localparam int PF  = teu_pkg::PF;
  localparam int LF  = teu_pkg::LF;
  localparam int NW  = teu_pkg::NW;
  localparam int NST = teu_pkg::NST;

  // Config registers
  logic [PW-1:0] persist_r, stay_r, recovery_r, gate_r;
  logic          vmode_r, update_r;

  // Pipeline
  teu_pkg::item_t st_r   [NST];
  teu_pkg::item_t st_nxt [NST];
  logic [NST-1:0] vld_r;
  logic           out_valid_r;
  logic [PW-1:0]  out_ex_r, out_vis_r;
  logic [PW-1:0]  out_ex_nxt, out_vis_nxt;
  logic           adv, in_fire;

  // Clamped config values
  logic [PW-1:0] pe_c, stay_c, rec_c, gate_c, lam, vden;

  // ---------------------------------------------------------------- helpers
  function automatic logic [PW-1:0] prob_in(input logic [PW-1:0] p);
    return (p > teu_pkg::ONE) ? teu_pkg::ONE : p;
  endfunction

  function automatic logic [2*PW-1:0] mul17(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return {{PW{1'b0}}, a} * {{PW{1'b0}}, b};
  endfunction

  function automatic teu_pkg::lane_t lane_init(input logic [PW-1:0] p, input logic tz);
    teu_pkg::lane_t l;
    logic [4:0]     k;
    l = '0;
    k = '0;
    for (int j = 0; j < PF; j++) begin
      if (p[j]) k = 5'(PF - j);
    end
    if (tz || p >= teu_pkg::ONE) l.code = teu_pkg::PW_ONE;
    else if (p == '0)            l.code = teu_pkg::PW_ZERO;
    else                         l.code = teu_pkg::PW_NORM;
    l.k = k;
    l.m = 31'(p) << (5'(30 - PF) + k);
    return l;
  endfunction

  function automatic teu_pkg::item_t stage_in(
      input logic kind, input logic [teu_pkg::IN_W-1:0] d,
      input logic [PW-1:0] pe, input logic [PW-1:0] lm,
      input logic [PW-1:0] rec, input logic [PW-1:0] gm, input logic [PW-1:0] vd);
    teu_pkg::item_t s;
    logic [2*PW-1:0] px;
    logic            tz;
    s      = '0;
    s.kind = kind;
    s.rr   = d[16:0];
    s.vr   = d[33:17];
    s.r    = prob_in(d[16:0]);
    s.v    = prob_in(d[33:17]);
    s.t    = d[65] ? 31'd0 : d[64:34];
    s.pd   = prob_in(d[82:66]);
    s.g    = d[130:83];
    s.lc   = d[178:131];
    px     = mul17(s.pd, gm);
    s.x    = px[PF+PW-1:PF];
    tz     = (s.t == 31'd0);
    s.le   = lane_init(pe, tz);
    s.ll   = lane_init(lm, tz);
    s.vrem = rec;
    s.vone = (rec >= vd);
    return s;
  endfunction

  function automatic teu_pkg::lane_t lane_log(input teu_pkg::lane_t l);
    logic [61:0] sq;
    sq = {31'b0, l.m} * {31'b0, l.m};
    if (sq[61]) begin
      l.m = sq[61:31];
      l.f = {l.f[LF-2:0], 1'b1};
    end else begin
      l.m = sq[60:30];
      l.f = {l.f[LF-2:0], 1'b0};
    end
    return l;
  endfunction

  function automatic teu_pkg::item_t log_step(
      input teu_pkg::item_t s, input logic dodiv, input logic [PW-1:0] vd);
    logic [PW:0] rem2;
    s.le = lane_log(s.le);
    s.ll = lane_log(s.ll);
    rem2 = {s.vrem, 1'b0};
    if (dodiv) begin
      if (rem2 >= {1'b0, vd}) begin
        s.vrem = PW'(rem2 - {1'b0, vd});
        s.vq   = {s.vq[PF-2:0], 1'b1};
      end else begin
        s.vrem = rem2[PW-1:0];
        s.vq   = {s.vq[PF-2:0], 1'b0};
      end
    end
    return s;
  endfunction

  function automatic teu_pkg::lane_t lane_xmul(input teu_pkg::lane_t l, input logic [30:0] t);
    logic [28:0] lg;
    logic [59:0] xp;
    logic [19:0] ipf;
    lg  = {l.k, {LF{1'b0}}} - 29'(l.f);
    xp  = {29'b0, t} * {31'b0, lg};
    ipf = xp[59:40];
    if (l.code == teu_pkg::PW_NORM && ipf > 20'(PF)) l.code = teu_pkg::PW_ZERO;
    l.ip = ipf[4:0];
    l.y  = xp[39:16];
    l.e  = 33'h1_0000_0000;
    return l;
  endfunction

  function automatic teu_pkg::item_t xmul_step(input teu_pkg::item_t s);
    s.le = lane_xmul(s.le, s.t);
    s.ll = lane_xmul(s.ll, s.t);
    return s;
  endfunction

  function automatic teu_pkg::lane_t lane_exp(
      input teu_pkg::lane_t l, input logic [4:0] pos, input logic [31:0] c);
    logic [64:0] p;
    p = {32'b0, l.e} * {33'b0, c};
    if (l.y[pos]) l.e = p[64:32];
    return l;
  endfunction

  function automatic teu_pkg::item_t exp_step(
      input teu_pkg::item_t s, input logic [4:0] pos, input logic [31:0] c);
    s.le = lane_exp(s.le, pos, c);
    s.ll = lane_exp(s.ll, pos, c);
    return s;
  endfunction

  function automatic teu_pkg::lane_t lane_pow(input teu_pkg::lane_t l);
    logic [5:0]  sh;
    logic [32:0] ev;
    sh = 6'(PF) + {1'b0, l.ip};
    ev = l.e >> sh;
    case (l.code)
      teu_pkg::PW_ONE:  l.pw = teu_pkg::ONE;
      teu_pkg::PW_ZERO: l.pw = '0;
      default:          l.pw = ev[PW-1:0];
    endcase
    return l;
  endfunction

  function automatic teu_pkg::item_t pow_step(input teu_pkg::item_t s);
    s.le = lane_pow(s.le);
    s.ll = lane_pow(s.ll);
    return s;
  endfunction

  // Predict existence and visibility
  function automatic teu_pkg::item_t pred_step(input teu_pkg::item_t s, input logic vimm);
    logic [2*PW-1:0] pr;
    logic [2*PW-1:0] pv;
    logic [PW-1:0]   vinf, dif, dd, vpn;
    logic            ge;
    pr   = mul17(s.le.pw, s.r);
    s.rp = pr[PF+PW-1:PF];
    vinf = s.vone ? teu_pkg::ONE : {1'b0, s.vq};
    ge   = (s.v >= vinf);
    dif  = ge ? (s.v - vinf) : (vinf - s.v);
    pv   = mul17(s.ll.pw, dif);
    dd   = pv[PF+PW-1:PF];
    vpn  = ge ? (vinf + dd) : (vinf - dd);
    s.vp = vimm ? prob_in(vpn) : s.v;
    return s;
  endfunction

  function automatic teu_pkg::item_t p1_step(input teu_pkg::item_t s, input logic vimm);
    logic [2*PW-1:0] rv, vx, rx;
    rv    = mul17(s.rp, s.vp);
    vx    = mul17(s.vp, s.x);
    rx    = mul17(s.rp, s.x);
    s.rvp = rv[32:0];
    s.a   = vimm ? rv[PF+PW-1:PF] : s.rp;
    s.vx  = vx[32:0];
    s.rx  = rx[32:0];
    s.omr = teu_pkg::ONE - s.rp;
    s.omx = teu_pkg::ONE - s.x;
    return s;
  endfunction

  function automatic teu_pkg::item_t p2_step(input teu_pkg::item_t s);
    logic [2*PW-1:0] ap, nv, ni;
    logic [49:0]     rvx;
    ap     = mul17(s.a, s.pd);
    nv     = mul17(s.vp, s.omx);
    ni     = mul17(s.rp, s.omx);
    rvx    = {17'b0, s.rvp} * {33'b0, s.x};
    s.apd  = ap[32:0];
    s.numv = nv[32:0];
    s.numi = ni[32:0];
    s.dv   = 33'h1_0000_0000 - s.vx;
    s.deni = 33'h1_0000_0000 - s.rx;
    s.denr = {1'b1, 48'b0} - rvx[48:0];
    s.lclo = {24'b0, s.omr} * {17'b0, s.lc[23:0]};
    s.lchi = {24'b0, s.omr} * {17'b0, s.lc[47:24]};
    return s;
  endfunction

  function automatic teu_pkg::item_t p3_step(input teu_pkg::item_t s);
    logic [49:0] nr;
    s.glo  = {24'b0, s.apd} * {33'b0, s.g[23:0]};
    s.ghi  = {24'b0, s.apd} * {33'b0, s.g[47:24]};
    nr     = {33'b0, s.rp} * {17'b0, s.dv};
    s.numr = nr;
    return s;
  endfunction

  function automatic teu_pkg::item_t p4_step(input teu_pkg::item_t s);
    s.hnum = 81'(s.glo) + {s.ghi, 24'b0};
    s.lct  = 65'(s.lclo) + {s.lchi, 24'b0};
    return s;
  endfunction

  // Pick numerator, denominator and fallback of both dividers
  function automatic teu_pkg::item_t sel_step(
      input teu_pkg::item_t s, input logic vimm, input logic upd);
    s.de      = '0;
    s.dvv     = '0;
    s.de.code  = teu_pkg::DV_RUN;
    s.dvv.code = teu_pkg::DV_RUN;
    s.de.fb   = s.rp;
    s.dvv.fb  = s.vp;
    if (!upd) begin
      s.de.code  = teu_pkg::DV_FB;
      s.de.fb    = s.rr;
      s.dvv.code = teu_pkg::DV_FB;
      s.dvv.fb   = s.vr;
    end else if (s.kind) begin
      if (!vimm && s.lc == '0) begin
        s.de.code = teu_pkg::DV_FB;
        s.de.fb   = (s.rp < teu_pkg::ONE) ? '0 : s.rp;
      end else begin
        s.de.num = NW'(s.hnum);
        s.de.den = NW'(s.hnum) + {1'b0, s.lct, 16'b0};
      end
      s.dvv.code = teu_pkg::DV_FB;
      s.dvv.fb   = vimm ? teu_pkg::ONE : s.vp;
    end else if (vimm) begin
      s.de.num  = NW'(s.numr);
      s.de.den  = NW'(s.denr);
      s.dvv.num = NW'(s.numv);
      s.dvv.den = NW'(s.dv);
    end else begin
      s.de.num   = NW'(s.numi);
      s.de.den   = NW'(s.deni);
      s.dvv.code = teu_pkg::DV_FB;
    end
    return s;
  endfunction

  function automatic teu_pkg::div_t div_init(input teu_pkg::div_t d);
    if (d.code != teu_pkg::DV_FB) begin
      if (d.den == '0)          d.code = teu_pkg::DV_FB;
      else if (d.num >= d.den)  d.code = teu_pkg::DV_ONE;
      else                      d.code = teu_pkg::DV_RUN;
    end
    return d;
  endfunction

  function automatic teu_pkg::item_t init_step(input teu_pkg::item_t s);
    s.de  = div_init(s.de);
    s.dvv = div_init(s.dvv);
    return s;
  endfunction

  function automatic teu_pkg::div_t div_one(input teu_pkg::div_t d);
    logic [NW:0] n2;
    n2 = {d.num, 1'b0};
    if (d.code == teu_pkg::DV_RUN) begin
      if (n2 >= {1'b0, d.den}) begin
        d.num = NW'(n2 - {1'b0, d.den});
        d.q   = {d.q[PF-2:0], 1'b1};
      end else begin
        d.num = n2[NW-1:0];
        d.q   = {d.q[PF-2:0], 1'b0};
      end
    end
    return d;
  endfunction

  function automatic teu_pkg::item_t div_step(input teu_pkg::item_t s);
    s.de  = div_one(s.de);
    s.dvv = div_one(s.dvv);
    return s;
  endfunction

  function automatic logic [PW-1:0] div_result(input teu_pkg::div_t d);
    logic [PW-1:0] res;
    case (d.code)
      teu_pkg::DV_FB:  res = d.fb;
      teu_pkg::DV_ONE: res = teu_pkg::ONE;
      default:         res = {1'b0, d.q};
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- config
  // Write config registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      persist_r  <= teu_pkg::ONE;
      stay_r     <= teu_pkg::ONE;
      recovery_r <= '0;
      gate_r     <= teu_pkg::ONE;
      vmode_r    <= 1'b0;
      update_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        teu_pkg::CFG_PERSIST:  persist_r  <= cfg_wdata;
        teu_pkg::CFG_STAY:     stay_r     <= cfg_wdata;
        teu_pkg::CFG_RECOVERY: recovery_r <= cfg_wdata;
        teu_pkg::CFG_GATE:     gate_r     <= cfg_wdata;
        teu_pkg::CFG_VMODE:    vmode_r    <= cfg_wdata[0];
        teu_pkg::CFG_UPDATE:   update_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Visibility chain rate and its steady-state divisor
  assign pe_c   = prob_in(persist_r);
  assign stay_c = prob_in(stay_r);
  assign rec_c  = prob_in(recovery_r);
  assign gate_c = prob_in(gate_r);

  always_comb begin
    lam = (stay_c > rec_c) ? (stay_c - rec_c) : '0;
    if (lam > teu_pkg::ONE - 1'b1) lam = teu_pkg::ONE - 1'b1;
  end
  assign vden = teu_pkg::ONE - lam;

  // ---------------------------------------------------------------- stages
  assign adv     = !out_valid_r || out_tready;
  assign in_fire = in_tvalid && adv;
  assign in_tready = adv;

  assign st_nxt[teu_pkg::ST_IN] =
      stage_in(in_tuser, in_tdata, pe_c, lam, rec_c, gate_c, vden);

  // log2 steps, with the steady-state visibility divide alongside
  for (genvar j = 1; j <= LF; j++) begin : g_log
    assign st_nxt[j] = log_step(st_r[j-1], (j <= PF), vden);
  end

  assign st_nxt[teu_pkg::ST_XMUL] = xmul_step(st_r[teu_pkg::ST_XMUL-1]);

  // exp2 steps, one constant factor each
  for (genvar i = 1; i <= LF; i++) begin : g_exp
    localparam logic [31:0] COEF = teu_pkg::exp_coef(i);
    assign st_nxt[teu_pkg::ST_EXP0+i-1] =
        exp_step(st_r[teu_pkg::ST_EXP0+i-2], 5'(LF - i), COEF);
  end

  assign st_nxt[teu_pkg::ST_POW]  = pow_step(st_r[teu_pkg::ST_POW-1]);
  assign st_nxt[teu_pkg::ST_PRED] = pred_step(st_r[teu_pkg::ST_PRED-1], vmode_r);
  assign st_nxt[teu_pkg::ST_P1]   = p1_step(st_r[teu_pkg::ST_P1-1], vmode_r);
  assign st_nxt[teu_pkg::ST_P2]   = p2_step(st_r[teu_pkg::ST_P2-1]);
  assign st_nxt[teu_pkg::ST_P3]   = p3_step(st_r[teu_pkg::ST_P3-1]);
  assign st_nxt[teu_pkg::ST_P4]   = p4_step(st_r[teu_pkg::ST_P4-1]);
  assign st_nxt[teu_pkg::ST_SEL]  = sel_step(st_r[teu_pkg::ST_SEL-1], vmode_r, update_r);
  assign st_nxt[teu_pkg::ST_INIT] = init_step(st_r[teu_pkg::ST_INIT-1]);

  // Posterior quotient bits, one per stage
  for (genvar i = 0; i < PF; i++) begin : g_div
    assign st_nxt[teu_pkg::ST_DIV0+i] = div_step(st_r[teu_pkg::ST_DIV0+i-1]);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_fire};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign out_ex_nxt  = div_result(st_r[NST-1].de);
  assign out_vis_nxt = div_result(st_r[NST-1].dvv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ex_r  <= out_ex_nxt;
      out_vis_r <= out_vis_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(teu_pkg::OUT_W - 2*PW){1'b0}}, out_vis_r, out_ex_r};

  // ---------------------------------------------------------------- checks
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r == $past(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_fire_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> vld_r[teu_pkg::ST_IN])
    else $error("accepted beat did not enter the first stage");

  a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[teu_pkg::ST_POW] |->
      (st_r[teu_pkg::ST_POW].le.pw <= teu_pkg::ONE) &&
      (st_r[teu_pkg::ST_POW].ll.pw <= teu_pkg::ONE))
    else $error("power lane result above one");

  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[teu_pkg::ST_INIT] && st_r[teu_pkg::ST_INIT].de.code == teu_pkg::DV_RUN |->
      st_r[teu_pkg::ST_INIT].de.num < st_r[teu_pkg::ST_INIT].de.den)
    else $error("existence divider started with numerator not below denominator");

endmodule

>>> bench/target_existence_update_check.sv
// Checker for target_existence_update: predicts each posterior and compares result beats.
`timescale 1ns / 100ps
module target_existence_update_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [teu_pkg::IN_W-1:0]   in_tdata,
  input  logic                       in_tuser,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [teu_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_we,
  input  logic [teu_pkg::CFG_IW-1:0] cfg_index,
  input  logic [teu_pkg::PW-1:0]     cfg_wdata,
  output int                         errors,
  output int                         pending
);

  localparam int PF = teu_pkg::PF;
  localparam int PW = teu_pkg::PW;
  localparam int LF = teu_pkg::LF;
  localparam logic [63:0] UNIT = 64'd1 << PF;

  // Shadow copy of the config registers
  logic [PW-1:0] persist_r, stay_r, recov_r, gate_r;
  logic          vimm_r, enable_r;

  // Expected posteriors, oldest first: {visibility, existence}
  logic [2*PW-1:0] posterior_q[$];
  int              seen;

  function automatic logic [63:0] clamp_prob(input logic [PW-1:0] p);
    return (p > teu_pkg::ONE) ? UNIT : 64'(p);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] rem, root, b;
    rem = n;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // p^t through a log2 / exp2 approximation, p in Q0.16, t in Q16.16
  function automatic logic [63:0] decay_pow(input logic [63:0] p, input logic [63:0] t);
    logic [63:0] m, f, l, x, ip, y, e, c;
    int k;
    if (t == 0 || p >= UNIT) return UNIT;
    if (p == 0) return 0;
    m = p;
    k = 0;
    f = 0;
    while (m < UNIT) begin
      m = m << 1;
      k++;
    end
    m = m << (30 - PF);
    for (int i = 0; i < LF; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    l = (64'(k) << LF) - f;
    x = (t * l) >> 16;
    ip = x >> LF;
    if (ip > PF) return 0;
    y = x & ((64'd1 << LF) - 1);
    e = 64'd1 << 32;
    c = floor_sqrt(64'd1 << 63);
    for (int i = 1; i <= LF; i++) begin
      if (y[LF-i]) e = (e * c) >> 32;
      c = floor_sqrt(c << 32);
    end
    return e >> (32 - PF + ip);
  endfunction

  // floor(num * 2^16 / den), saturated at 1.0, fallback on a zero denominator
  function automatic logic [63:0] ratio_q16(input logic [127:0] num, input logic [127:0] den,
                                            input logic [63:0] fallback);
    logic [63:0] q;
    if (den == 0) return fallback;
    if (num >= den) return UNIT;
    q = 0;
    for (int i = 0; i < PF; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // Existence and visibility posterior of one hypothesis beat
  function automatic logic [2*PW-1:0] posterior_of(input logic hit,
                                                   input logic [teu_pkg::IN_W-1:0] d);
    logic [63:0] r, v, t, pd, rp, vp, ro, vo, stay, rec, lam, vinf, pw, a, x, rf;
    logic [127:0] g, lc, num, den, one3;
    logic [31:0] et;
    if (!enable_r) return {d[33:17], d[16:0]};
    r = clamp_prob(d[16:0]);
    v = clamp_prob(d[33:17]);
    et = d[65:34];
    t = et[31] ? 64'd0 : 64'(et);
    pd = clamp_prob(d[82:66]);
    g = 128'(d[130:83]);
    lc = 128'(d[178:131]);
    one3 = 128'(UNIT) * UNIT * UNIT;
    rp = (decay_pow(clamp_prob(persist_r), t) * r) >> PF;
    vp = v;
    if (vimm_r) begin
      stay = clamp_prob(stay_r);
      rec = clamp_prob(recov_r);
      lam = (stay > rec) ? stay - rec : 0;
      if (lam > UNIT - 1) lam = UNIT - 1;
      vinf = (rec << PF) / (UNIT - lam);
      if (vinf > UNIT) vinf = UNIT;
      pw = decay_pow(lam, t);
      if (v >= vinf) vp = vinf + ((pw * (v - vinf)) >> PF);
      else vp = vinf - ((pw * (vinf - v)) >> PF);
      if (vp > UNIT) vp = UNIT;
    end
    if (hit) begin
      if (!vimm_r && lc == 0) begin
        ro = (rp < UNIT) ? 0 : rp;
      end else begin
        a = vimm_r ? ((rp * vp) >> PF) : rp;
        num = 128'(a * pd) * g;
        den = num + 128'((UNIT - rp) * UNIT) * lc;
        ro = ratio_q16(num, den, rp);
      end
      vo = vimm_r ? UNIT : vp;
    end else begin
      x = (pd * clamp_prob(gate_r)) >> PF;
      if (vimm_r) begin
        rf = UNIT * UNIT - vp * x;
        ro = ratio_q16(128'(rp) * rf, one3 - 128'(rp * vp) * x, rp);
        vo = ratio_q16(128'(vp * (UNIT - x)), 128'(UNIT * UNIT - vp * x), vp);
      end else begin
        ro = ratio_q16(128'(rp * (UNIT - x)), 128'(UNIT * UNIT - rp * x), rp);
        vo = vp;
      end
    end
    if (ro > UNIT) ro = UNIT;
    if (vo > UNIT) vo = UNIT;
    return {vo[PW-1:0], ro[PW-1:0]};
  endfunction

  task automatic report(input string what, input logic [PW-1:0] got, input logic [PW-1:0] want);
    $display("ERROR result %0d: %s got %0d expected %0d", seen, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    seen = 0;
  end

  // Track config, queue predictions, check result beats
  always @(posedge clk) begin
    logic [2*PW-1:0] want;
    if (!rst_n) begin
      persist_r <= teu_pkg::ONE;
      stay_r    <= teu_pkg::ONE;
      recov_r   <= '0;
      gate_r    <= teu_pkg::ONE;
      vimm_r    <= 1'b0;
      enable_r  <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          teu_pkg::CFG_PERSIST:  persist_r <= cfg_wdata;
          teu_pkg::CFG_STAY:     stay_r    <= cfg_wdata;
          teu_pkg::CFG_RECOVERY: recov_r   <= cfg_wdata;
          teu_pkg::CFG_GATE:     gate_r    <= cfg_wdata;
          teu_pkg::CFG_VMODE:    vimm_r    <= cfg_wdata[0];
          teu_pkg::CFG_UPDATE:   enable_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        posterior_q.insert(posterior_q.size(), posterior_of(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (posterior_q.size() == 0) begin
          report("unexpected existence_post", out_tdata[16:0], '0);
        end else begin
          want = posterior_q.pop_front();
          if (out_tdata[16:0] !== want[PW-1:0])
            report("existence_post", out_tdata[16:0], want[PW-1:0]);
          if (out_tdata[33:17] !== want[2*PW-1:PW])
            report("visibility_post", out_tdata[33:17], want[2*PW-1:PW]);
        end
        seen++;
      end
    end
    pending = posterior_q.size();
  end

endmodule

>>> bench/target_existence_update_test.sv
// Top of the target_existence_update bench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module target_existence_update_test;

  localparam int PW = teu_pkg::PW;
  localparam int DW = teu_pkg::DW;
  localparam logic [PW-1:0] MAXP = '1;
  localparam logic [DW-1:0] MAXD = '1;

  // Unmapped register indexes
  localparam logic [teu_pkg::CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [teu_pkg::CFG_IW-1:0] CFG_SPARE_HI = 3'd7;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [teu_pkg::IN_W-1:0]   in_tdata = '0;
  logic                       in_tuser = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [teu_pkg::OUT_W-1:0]  out_tdata;
  logic                       cfg_we = 1'b0;
  logic [teu_pkg::CFG_IW-1:0] cfg_index = teu_pkg::CFG_PERSIST;
  logic [PW-1:0]              cfg_wdata = '0;

  int errors, pending;
  int beats_sent = 0;
  int phases = 0;
  bit quiet = 1'b0;

  target_existence_update dut (.*);

  target_existence_update_check checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("target_existence_update_test: errors");
    $finish;
  end

  // Result side: random stall before each beat, none in quiet stretches
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Send one hypothesis beat after a random gap
  task automatic send_hyp(input logic hit, input logic [PW-1:0] r, input logic [PW-1:0] v,
                          input logic [31:0] et, input logic [PW-1:0] pd,
                          input logic [DW-1:0] g, input logic [DW-1:0] lc);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= hit;
    in_tdata  <= {5'b0, lc, g, pd, et, v, r};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Hold input, let every result drain, then wait out the pipeline
  task automatic drain_all();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // One write, then cfg_we is lowered and held off so back-to-back writes never collide
  task automatic write_reg(input logic [teu_pkg::CFG_IW-1:0] idx, input logic [PW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_cfg(input logic [PW-1:0] pe, input logic [PW-1:0] st,
                          input logic [PW-1:0] rc, input logic [PW-1:0] gm,
                          input logic [PW-1:0] vm, input logic [PW-1:0] en);
    drain_all();
    write_reg(teu_pkg::CFG_PERSIST, pe);
    write_reg(teu_pkg::CFG_STAY, st);
    write_reg(teu_pkg::CFG_RECOVERY, rc);
    write_reg(teu_pkg::CFG_GATE, gm);
    write_reg(teu_pkg::CFG_VMODE, vm);
    write_reg(teu_pkg::CFG_UPDATE, en);
    phases++;
  endtask

  function automatic logic [PW-1:0] rand_prob();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return teu_pkg::ONE;
      2: return PW'($urandom_range(0, 2**PW - 1));
      default: return PW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return $urandom;
      2: return -$urandom_range(1, 1 << 20);
      3: return $urandom_range(0, 64 << 16);
      default: return $urandom_range(1, 8 << 16);
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_density();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DW'({$urandom, $urandom});
      2: return MAXD;
      default: return DW'($urandom_range(1, 1 << 30)) << $urandom_range(0, 17);
    endcase
  endfunction

  // Field extremes, both branches, clutter and time corner cases
  task automatic directed_set();
    send_hyp(1'b0, teu_pkg::ONE, teu_pkg::ONE, 32'h0001_0000, teu_pkg::ONE, '0, '0);
    send_hyp(1'b0, '0, '0, 32'h0001_0000, '0, '0, '0);
    send_hyp(1'b0, MAXP, MAXP, 32'h8000_0000, MAXP, MAXD, MAXD);
    send_hyp(1'b1, MAXP, MAXP, 32'h7FFF_FFFF, MAXP, MAXD, MAXD);
    send_hyp(1'b1, 17'd32768, 17'd32768, 32'h0002_0000, 17'd52428, 48'h1_000000, '0);
    send_hyp(1'b1, teu_pkg::ONE, teu_pkg::ONE, '0, teu_pkg::ONE, 48'h1_000000, '0);
    send_hyp(1'b1, '0, 17'd40000, 32'h0000_8000, 17'd60000, '0, 48'h0_800000);
    send_hyp(1'b1, 17'd1000, 17'd65000, 32'h0001_0000, 17'd50000, MAXD, 48'd1);
    send_hyp(1'b1, 17'd30000, '0, 32'h0001_0000, '0, 48'h5_000000, 48'h2_000000);
    send_hyp(1'b0, 17'd50000, 17'd20000, 32'hFFFF_0000, 17'd58982, '0, '0);
    send_hyp(1'b0, 17'd50000, 17'd20000, '0, 17'd58982, MAXD, MAXD);
    send_hyp(1'b0, 17'd65535, 17'd65535, 32'h0000_0001, 17'd65535, '0, '0);
    send_hyp(1'b0, 17'd12345, 17'd54321, 32'h0040_0000, 17'd30000, '0, '0);
    send_hyp(1'b1, 17'd12345, 17'd54321, 32'h0010_0000, 17'd30000, 48'h2_5A0000, 48'h0_010000);
    send_hyp(1'b1, 17'd1, 17'd1, 32'h0000_4000, 17'd1, 48'd1, MAXD);
  endtask

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_hyp(1'($urandom_range(0, 1)), rand_prob(), rand_prob(), rand_time(), rand_prob(),
               rand_density(), rand_density());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults, IPDA
    directed_set();
    random_run(90);

    // IPDA with decay, partial gate, unknown index must be ignored
    load_cfg(17'd58982, teu_pkg::ONE, '0, 17'd62259, '0, 17'd1);
    write_reg(CFG_SPARE_LO, 17'h1_5555);
    write_reg(CFG_SPARE_HI, '0);
    random_run(110);

    // VIMM, typical chain
    load_cfg(17'd62259, 17'd58982, 17'd6554, 17'd64880, 17'd1, 17'd1);
    directed_set();
    random_run(110);

    // VIMM extremes: zero persistence and gate, recovery at one
    load_cfg('0, '0, teu_pkg::ONE, '0, 17'd1, 17'd1);
    random_run(90);

    // VIMM with registers above one, upper bits in the mode words
    load_cfg(MAXP, MAXP, MAXP, MAXP, 17'h1_FFFF, 17'h1_FFFF);
    random_run(90);

    // VIMM, stay below recovery
    load_cfg(17'd33000, 17'd10000, 17'd30000, teu_pkg::ONE, 17'd1, 17'd1);
    random_run(90);

    // Updates disabled: raw priors pass through
    load_cfg(17'd40000, 17'd50000, 17'd1000, 17'd30000, 17'd1, 17'h1_FFFE);
    random_run(60);

    // IPDA, mode word with upper bits only
    load_cfg(17'd65000, teu_pkg::ONE, '0, teu_pkg::ONE, 17'h1_FFFE, 17'd1);
    random_run(110);

    drain_all();
    $display("Sent %0d hypothesis beats over %0d config phases (IPDA, VIMM, pass-through),",
             beats_sent, phases + 1);
    $display("hit and miss branches with time, clutter and probability extremes.");
    if (errors == 0) begin
      $display("target_existence_update_test: clean");
    end else begin
      $display("target_existence_update_test: errors");
    end
    $finish;
  end

endmodule
